>>> src/itoa_pkg.sv
// Shared types, codes and character constants of the integer to ASCII converter.
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] RADIX_BIN = 8'd2;
    localparam logic [7:0] RADIX_OCT = 8'd8;
    localparam logic [7:0] RADIX_DEC = 8'd10;
    localparam logic [7:0] RADIX_HEX = 8'd16;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [3:0] DIGIT_TEN    = 4'd10;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_BIN,
        KIND_OCT,
        KIND_DEC,
        KIND_HEX
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  neg;
    } t_cls;

    // Digit value 0 to 15 to its ASCII symbol, upper case above nine.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ext;
        ext = {4'b0000, d};
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + ext;
        end
        return CHAR_UPPER_A + ext - {4'b0000, DIGIT_TEN};
    endfunction

endpackage

>>> src/itoa_if.sv
// Request channel interfaces: integer input and character output.
interface itoa_in_if
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [7:0]                    radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink (input valid, input value, input radix, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink (input valid, input text_char, input last, output ready);
endinterface

>>> src/itoa_front.sv
// Front end: classifies a request by radix and sign and aligns its magnitude.
module itoa_front
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int MAG_W = VALUE_WIDTH + 3
) (
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic [7:0]                    i_radix,
    output t_cls                          o_cls,
    output logic [MAG_W-1:0]              o_mag
);
    localparam int ND_OCT = (VALUE_WIDTH + 2) / 3;
    localparam int ND_HEX = (VALUE_WIDTH + 3) / 4;
    localparam int SH_STD = MAG_W - VALUE_WIDTH;
    localparam int SH_OCT = MAG_W - 3 * ND_OCT;
    localparam int SH_HEX = MAG_W - 4 * ND_HEX;

    t_kind                  kind;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic [MAG_W-1:0]       ext;

    always_comb begin
        case (i_radix)
            RADIX_BIN: kind = KIND_BIN;
            RADIX_OCT: kind = KIND_OCT;
            RADIX_DEC: kind = KIND_DEC;
            RADIX_HEX: kind = KIND_HEX;
            default:   kind = KIND_NONE;
        endcase
    end

    // Only decimal requests carry a sign; other bases read the raw pattern.
    assign raw = i_value;
    assign neg = (kind == KIND_DEC) && raw[VALUE_WIDTH-1];
    assign mag = neg ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
    assign ext = {3'b000, mag};

    // Left-align so that the most significant digit group sits at the top.
    always_comb begin
        case (kind)
            KIND_OCT: o_mag = ext << SH_OCT;
            KIND_HEX: o_mag = ext << SH_HEX;
            default:  o_mag = ext << SH_STD;
        endcase
    end

    assign o_cls.kind = kind;
    assign o_cls.neg  = neg;
endmodule

>>> src/itoa_queue.sv
// Short command queue between the front end and the digit engine.
module itoa_queue
    import itoa_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end
endmodule

>>> src/itoa_back.sv
// Digit engine: binary to BCD conversion, digit emission and the output register.
module itoa_back
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int MAG_W = VALUE_WIDTH + 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cls             i_cls,
    input  logic [MAG_W-1:0] i_mag,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_char,
    output logic             o_last
);
    // Decimal digit slots: log10(2) is just above 0.3, plus one slot of margin.
    localparam int NDEC   = (VALUE_WIDTH * 3) / 10 + 2;
    localparam int BCD_W  = 4 * NDEC;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int ND_OCT = (VALUE_WIDTH + 2) / 3;
    localparam int ND_HEX = (VALUE_WIDTH + 3) / 4;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DABBLE = 5'b00010,
        ST_SIGN   = 5'b00100,
        ST_DIGIT  = 5'b01000,
        ST_TERM   = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    t_kind            r_kind, n_kind;
    logic             r_neg, n_neg;
    logic             r_started, n_started;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char, n_out_char;
    logic             r_out_last, n_out_last;

    logic             slot_free;
    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_last;
    logic [3:0]       top4;
    logic [3:0]       dig;
    logic [MAG_W-1:0] mag_next;
    logic [BCD_W-1:0] bcd_adj;
    logic             lead_zero;

    assign slot_free = !r_out_valid || i_ready;
    assign top4      = r_mag[MAG_W-1 -: 4];

    // Shift-add-3 correction on every BCD digit before the next bit enters.
    always_comb begin
        for (int k = 0; k < NDEC; k++) begin
            bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ?
                                (r_bcd[4*k +: 4] + 4'd3) : r_bcd[4*k +: 4];
        end
    end

    always_comb begin
        case (r_kind)
            KIND_BIN: begin
                dig      = {3'b000, top4[3]};
                mag_next = r_mag << 1;
            end
            KIND_OCT: begin
                dig      = {1'b0, top4[3:1]};
                mag_next = r_mag << 3;
            end
            KIND_HEX: begin
                dig      = top4;
                mag_next = r_mag << 4;
            end
            KIND_DEC: begin
                dig      = r_bcd[BCD_W-1 -: 4];
                mag_next = r_mag;
            end
            default: begin
                dig      = 4'd0;
                mag_next = r_mag;
            end
        endcase
    end

    // A zero before the first significant digit is dropped, but never the last one.
    assign lead_zero = (dig == 4'd0) && !r_started && (r_cnt != CNT_ONE);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_neg     = r_neg;
        n_started = r_started;
        n_cnt     = r_cnt;
        n_mag     = r_mag;
        n_bcd     = r_bcd;
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = CHAR_NUL;
        emit_last = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop     = 1'b1;
                    n_kind    = i_cls.kind;
                    n_neg     = i_cls.neg;
                    n_mag     = i_mag;
                    n_bcd     = '0;
                    n_started = 1'b0;
                    case (i_cls.kind)
                        KIND_BIN: begin
                            n_cnt   = CNT_W'(VALUE_WIDTH);
                            n_state = ST_DIGIT;
                        end
                        KIND_OCT: begin
                            n_cnt   = CNT_W'(ND_OCT);
                            n_state = ST_DIGIT;
                        end
                        KIND_HEX: begin
                            n_cnt   = CNT_W'(ND_HEX);
                            n_state = ST_DIGIT;
                        end
                        KIND_DEC: begin
                            n_cnt   = CNT_W'(VALUE_WIDTH);
                            n_state = ST_DABBLE;
                        end
                        default: begin
                            n_state = ST_TERM;
                        end
                    endcase
                end
            end
            ST_DABBLE: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_mag[MAG_W-1]};
                n_mag = r_mag << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_ONE) begin
                    n_cnt   = CNT_W'(NDEC);
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_char = CHAR_MINUS;
                    n_state   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (lead_zero || slot_free) begin
                    n_mag = mag_next;
                    n_bcd = r_bcd << 4;
                    n_cnt = r_cnt - 1'b1;
                    if (!lead_zero) begin
                        emit      = 1'b1;
                        emit_char = digit_char(dig);
                        n_started = 1'b1;
                        if (r_cnt == CNT_ONE) begin
                            n_state = ST_TERM;
                        end
                    end
                end
            end
            ST_TERM: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_char = CHAR_NUL;
                    emit_last = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_char  = emit_char;
            n_out_last  = emit_last;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_neg      <= n_neg;
        r_started  <= n_started;
        r_cnt      <= n_cnt;
        r_mag      <= n_mag;
        r_bcd      <= n_bcd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;
endmodule

>>> src/integer_to_ascii_digits.sv
// Top level of the integer to ASCII converter: front end, command queue and digit engine.
//
// Each request carries a signed integer and a radix; the block answers with the ASCII
// text of the number, most significant digit first, upper case A to F above nine,
// followed by a NUL character flagged as last. Radix 2, 8, 10 and 16 give digits; any
// other radix gives the NUL alone. In radix 10 a negative value is written as '-' and its
// magnitude, the most negative value included; the other radices read the bit pattern
// as an unsigned VALUE_WIDTH-bit number, and zero gives "0". The front end classifies a
// request and aligns its magnitude in the same cycle it is accepted, and a two-entry
// command queue lets up to two further requests wait while the digit engine works. The
// engine picks a command off the queue in its idle state. In radix 2, 8 and 16 it then
// steps through every digit position of the full width (VALUE_WIDTH, ceil(VALUE_WIDTH/3)
// or ceil(VALUE_WIDTH/4); leading zeros are skipped at one a cycle), each digit waiting
// for a free output register, and then the NUL. In radix 10 the shift-add-3 binary to BCD
// loop takes one bit a cycle over all VALUE_WIDTH bits, followed by the sign when present,
// the BCD digit slots (3*VALUE_WIDTH/10 + 2) with leading zeros dropped, and the NUL. That
// loop is the longest step of a decimal request. Results leave through a registered
// output, so a character waiting for its consumer does not keep the queue from taking
// new requests.
module integer_to_ascii_digits
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itoa_in_if.sink   i_in,
    itoa_out_if.source o_out
);
    localparam int MAG_W = VALUE_WIDTH + 3;
    localparam int CMD_W = MAG_W + $bits(t_cls);

    t_cls             front_cls;
    logic [MAG_W-1:0] front_mag;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [CMD_W-1:0] q_head;
    t_cls             head_cls;
    logic [MAG_W-1:0] head_mag;

    itoa_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_value (i_in.value),
        .i_radix (i_in.radix),
        .o_cls   (front_cls),
        .o_mag   (front_mag)
    );

    // A request is taken whenever the queue has a free entry.
    assign i_in.ready = !q_full;

    itoa_queue #(
        .DATA_W (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid),
        .i_data  ({front_mag, front_cls}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    assign head_cls = q_head[$bits(t_cls)-1:0];
    assign head_mag = q_head[CMD_W-1 -: MAG_W];

    itoa_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_empty),
        .i_cls       (head_cls),
        .i_mag       (head_mag),
        .o_pop       (q_pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_char      (o_out.text_char),
        .o_last      (o_out.last)
    );
endmodule

>>> src/itoa_checker.sv
// Port-level checker of the integer to ASCII converter and its bind to the top level.
module itoa_checker
    import itoa_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);
    logic       in_acc;
    logic       out_acc;
    logic [3:0] r_pend;
    logic       r_after_minus;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Requests taken whose terminating NUL has not yet been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend        <= '0;
            r_after_minus <= 1'b0;
        end else begin
            r_pend <= r_pend + {3'b000, in_acc} - {3'b000, out_acc && i_out_last};
            if (out_acc) begin
                r_after_minus <= (i_out_char == CHAR_MINUS);
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_char) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 4'd0)
        else $error("character offered with no request outstanding");

    a_sign_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_after_minus |-> (i_out_char > CHAR_ZERO) && (i_out_char <= CHAR_NINE))
        else $error("minus sign not followed by a nonzero decimal digit");
endmodule

bind integer_to_ascii_digits itoa_checker u_itoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.text_char),
    .i_out_last  (o_out.last)
);

>>> test/testbench.sv
// Self-checking testbench of the integer to ASCII converter, with its own text predictor.
`timescale 1ns / 1ps

module testbench;
    import itoa_pkg::*;

    localparam int VALUE_WIDTH  = 32;
    localparam int NUM_RANDOM   = 96;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 300000;

    // One request as the driver presents it: an integer and the base to print it in.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [7:0]             radix;
    } t_request;

    // One expected character of the text.
    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    itoa_in_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_if ();
    itoa_out_if                             out_if ();

    integer_to_ascii_digits #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Requests waiting to be offered and characters waiting to come back.
    t_request   pending_requests[$];
    t_text_char expected_text[$];

    // Handshake pattern: 0 has a dense sender and a busy receiver, 1 the reverse,
    // 2 runs both sides at full rate after one long receiver hold-off.
    int          pattern;
    int          hold_count;
    bit          hold_done;
    int unsigned n_requests;
    int unsigned n_chars;
    int unsigned n_errors;
    int unsigned n_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every block input carries a known value from time zero, while reset is held low.
    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.value     = '0;
        in_if.radix     = '0;
        out_if.ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic bit sender_idles();
        int pct;
        pct = (pattern == 0) ? 14 : (pattern == 1) ? 55 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit receiver_idles();
        int pct;
        pct = (pattern == 0) ? 55 : (pattern == 1) ? 14 : 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    // Works out the full text of one request and appends it to the expected characters.
    // Radix 10 prints a sign and the magnitude; the other supported radices read the
    // pattern as unsigned. Two's complement negation of the most negative value gives
    // back the same pattern, which read unsigned is exactly its magnitude.
    function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value,
                                         input logic [7:0] radix);
        string                  symbols;
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [VALUE_WIDTH-1:0] base;
        logic [7:0]             digits[$];
        bit                     negative;
        symbols = "0123456789ABCDEF";
        if (radix != RADIX_BIN && radix != RADIX_OCT && radix != RADIX_DEC
                && radix != RADIX_HEX) begin
            expected_text.push_back('{text_char: CHAR_NUL, last: 1'b1});
            return;
        end
        base      = {{(VALUE_WIDTH-8){1'b0}}, radix};
        negative  = (radix == RADIX_DEC) && value[VALUE_WIDTH-1];
        magnitude = negative ? -value : value;
        do begin
            digits.push_front(symbols[magnitude % base]);
            magnitude = magnitude / base;
        end while (magnitude != 0);
        if (negative) begin
            expected_text.push_back('{text_char: CHAR_MINUS, last: 1'b0});
        end
        foreach (digits[i]) begin
            expected_text.push_back('{text_char: digits[i], last: 1'b0});
        end
        expected_text.push_back('{text_char: CHAR_NUL, last: 1'b1});
    endfunction

    // Driver: each accepted request is predicted at the edge that takes it, and the next
    // one is offered only when the channel is free or has just moved a request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_text(in_if.value, in_if.radix);
                n_requests++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_requests.size() != 0 && !sender_idles()) begin
                    in_if.value <= pending_requests[0].value;
                    in_if.radix <= pending_requests[0].radix;
                    in_if.valid <= 1'b1;
                    void'(pending_requests.pop_front());
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once when the full-rate pattern begins. The sender
    // keeps offering during it, so the command queue fills and the input must stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_count <= 0;
            hold_done  <= 1'b0;
        end else if (pattern == 2 && !hold_done) begin
            hold_count <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end
    end

    // Monitor: every accepted character is compared with the oldest expected one.
    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_chars++;
                if (expected_text.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected character: expected none, actual char=%h last=%b",
                             $time, out_if.text_char, out_if.last);
                end else begin
                    want = expected_text.pop_front();
                    if (out_if.text_char !== want.text_char) begin
                        n_errors++;
                        $display("%0t: text_char mismatch: expected %h, actual %h",
                                 $time, want.text_char, out_if.text_char);
                    end
                    if (out_if.last !== want.last) begin
                        n_errors++;
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, out_if.last);
                    end
                end
            end
            out_if.ready <= (hold_count == 0) && !receiver_idles();
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d characters outstanding.",
                     n_cycles, expected_text.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [VALUE_WIDTH-1:0] random_value();
        logic [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 40);
            2: v = -$urandom_range(1, 40);
            default: begin
                v = $urandom_range(0, 1) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                         : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                v = v ^ $urandom_range(0, 3);
            end
        endcase
        return v;
    endfunction

    function automatic logic [7:0] random_radix();
        logic [7:0] r;
        case ($urandom_range(0, 9))
            0, 1:    r = RADIX_BIN;
            2, 3:    r = RADIX_OCT;
            4, 5:    r = RADIX_DEC;
            6, 7:    r = RADIX_HEX;
            default: r = $urandom_range(0, 255);
        endcase
        return r;
    endfunction

    task automatic queue_request(input logic [VALUE_WIDTH-1:0] value, input logic [7:0] radix);
        pending_requests.push_back('{value: value, radix: radix});
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            queue_request(random_value(), random_radix());
        end
    endtask

    task automatic wait_sent();
        while (pending_requests.size() != 0 || in_if.valid) @(negedge i_clk);
    endtask

    // Stimulus. All pattern changes are made on the falling edge, away from the
    // sampling edge of the driver and the monitor.
    initial begin
        logic [VALUE_WIDTH-1:0] most_neg;
        logic [VALUE_WIDTH-1:0] most_pos;
        most_neg   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        most_pos   = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        pattern    = 0;
        n_requests = 0;
        n_chars    = 0;
        n_errors   = 0;
        n_cycles   = 0;

        // Zero in every supported base.
        queue_request('0, RADIX_BIN);
        queue_request('0, RADIX_OCT);
        queue_request('0, RADIX_DEC);
        queue_request('0, RADIX_HEX);
        // Largest positive value, with long runs of digits.
        queue_request(most_pos, RADIX_BIN);
        queue_request(most_pos, RADIX_DEC);
        queue_request(most_pos, RADIX_HEX);
        // Most negative value: full magnitude in decimal, plain pattern elsewhere.
        queue_request(most_neg, RADIX_DEC);
        queue_request(most_neg, RADIX_OCT);
        queue_request(most_neg, RADIX_HEX);
        // All ones: minus one in decimal, the widest unsigned pattern otherwise.
        queue_request('1, RADIX_DEC);
        queue_request('1, RADIX_BIN);
        queue_request('1, RADIX_OCT);
        queue_request('1, RADIX_HEX);
        // Digit boundaries: nine to ten, and the top hex digit.
        queue_request(9, RADIX_DEC);
        queue_request(10, RADIX_DEC);
        queue_request(32'hABCDEF09, RADIX_HEX);
        // Unsupported bases give the terminator alone.
        queue_request(1234, 8'd0);
        queue_request(1234, 8'd1);
        queue_request(-5, 8'd3);
        queue_request(77, 8'd9);
        queue_request(77, 8'd17);
        queue_request(most_neg, 8'd255);

        queue_random(NUM_RANDOM / 3);
        wait_sent();

        @(negedge i_clk);
        pattern = 1;
        queue_random(NUM_RANDOM / 3);
        wait_sent();

        @(negedge i_clk);
        pattern = 2;
        queue_random(NUM_RANDOM - 2 * (NUM_RANDOM / 3));
        wait_sent();

        while (expected_text.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d conversion requests and checked %0d characters of text,",
                 n_requests, n_chars);
        $display("over sparse, busy, full-rate and held-off handshakes; %0d mismatches.",
                 n_errors);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
